FILE: rtl/sorted_insert_queue_core_macros.svh
// Assertion macros for the sorted insert queue checker.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SORTED_INSERT_QUEUE_CORE_MACROS_SVH
`define SORTED_INSERT_QUEUE_CORE_MACROS_SVH

// Consequent is checked in the same cycle as the antecedent.
`define SIQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent is checked in the cycle after the antecedent.
`define SIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/siq_pkg.sv
// Shared types and constants for the sorted insert queue.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps

package siq_pkg;

	localparam int DATA_W = 32;
	localparam int REQ_W  = 2;
	localparam int OCC_W  = 5;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_PUSH,
		OP_POP
	} op_t;

	// Broadcast to every cell during the update cycle.
	typedef struct packed {
		op_t   op;
		data_t value;
	} cell_ctl_t;

endpackage

FILE: rtl/siq_cell.sv
// One storage cell of the sorted insert queue: holds one entry and its compare flag.
// Depends on siq_pkg.
`timescale 1ns / 1ps

module siq_cell (
	input  logic              clk,
	input  logic              cmp_en,
	input  siq_pkg::data_t    cmp_val,
	input  logic              valid,
	input  logic              is_tail,
	input  logic              found_left,
	input  siq_pkg::cell_ctl_t ctl,
	input  siq_pkg::data_t    left_entry,
	input  siq_pkg::data_t    right_entry,
	output siq_pkg::data_t    entry,
	output logic              ge
);
	import siq_pkg::*;

	data_t entry_q;
	logic  ge_q;

	// The compare result is captured when the request is accepted and used in the following cycle.
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			ge_q <= valid && (entry_q >= cmp_val);
		end
		case (ctl.op)
			OP_INSERT: begin
				// Cells behind the insert point shift toward the tail.
				if (found_left) begin
					entry_q <= left_entry;
				end else if (ge_q || is_tail) begin
					entry_q <= ctl.value;
				end
			end
			OP_PUSH: begin
				entry_q <= left_entry;
			end
			OP_POP: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	assign ge    = ge_q;

endmodule

FILE: rtl/sorted_insert_queue_core.sv
// Top level of the sorted insert queue: control, entry count and a row of storage cells.
// Depends on siq_pkg and siq_cell.
`timescale 1ns / 1ps

// Usage:
// A request is presented on req_type and value with start high; it is taken at a
// rising edge where start is high and busy is low. busy then stays high for one
// cycle while the cells apply the request, so no new request is taken before
// the cells have applied the last one.
// In the cycle of acceptance every cell compares its entry with the new value.
// In the busy cycle of an insert the first cell whose entry is greater or equal (found
// through a carry passed from cell to cell), or else the tail cell, takes the value, the
// cells behind it take their left neighbor's entry, and the count is updated.
// The result (popped_value, empty_error, full_error, occupancy) is registered in the
// busy cycle and appears with done, the registered busy, high for exactly one cycle;
// the transfer completes at the edge ending that cycle. The receiver cannot stall,
// so there is no backpressure on the result side.
// Reset clears the count (empty list), busy and done; stored entries are not cleared
// and no clearing pass is needed.

module sorted_insert_queue_core #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [siq_pkg::REQ_W-1:0]     req_type,
	input  logic signed [siq_pkg::DATA_W-1:0] value,
	output logic                          done,
	output logic signed [siq_pkg::DATA_W-1:0] popped_value,
	output logic                          empty_error,
	output logic                          full_error,
	output logic [siq_pkg::OCC_W-1:0]     occupancy
);
	import siq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic              busy_q;
	logic              done_q;
	logic [REQ_W-1:0]  req_s1;
	data_t             val_s1;
	logic [CW-1:0]     count_q;
	data_t             popped_q;
	logic              empty_err_q;
	logic              full_err_q;
	logic [OCC_W-1:0]  occ_q;

	logic              accept;
	logic              is_full;
	logic              is_empty;
	cell_ctl_t         ctl;
	logic [CW-1:0]     count_next;
	logic [CW+OCC_W-1:0] count_ext;

	data_t             entry_w [DEPTH];
	logic [DEPTH-1:0]  ge_w;
	logic [DEPTH:0]    found_w;
	logic [DEPTH-1:0]  valid_w;
	logic [DEPTH-1:0]  tail_w;

	assign accept   = start && !busy_q;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctl.op     = OP_NONE;
		ctl.value  = val_s1;
		count_next = count_q;
		if (busy_q) begin
			case (req_s1)
				REQ_INSERT: begin
					if (!is_full) begin
						ctl.op     = OP_INSERT;
						count_next = count_q + CW'(1);
					end
				end
				REQ_PUSH: begin
					if (!is_full) begin
						ctl.op     = OP_PUSH;
						count_next = count_q + CW'(1);
					end
				end
				REQ_POP: begin
					if (!is_empty) begin
						ctl.op     = OP_POP;
						count_next = count_q - CW'(1);
					end
				end
				default: begin
					ctl.op = OP_NONE;
				end
			endcase
		end
	end

	assign count_ext = {{OCC_W{1'b0}}, count_next};

	assign found_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign valid_w[i]   = (count_q >= CW'(i + 1));
		assign tail_w[i]    = (count_q == CW'(i));
		assign found_w[i+1] = found_w[i] || ge_w[i];

		siq_cell u_cell (
			.clk         (clk),
			.cmp_en      (accept),
			.cmp_val     (value),
			.valid       (valid_w[i]),
			.is_tail     (tail_w[i]),
			.found_left  (found_w[i]),
			.ctl         (ctl),
			.left_entry  ((i == 0) ? val_s1 : entry_w[(i == 0) ? 0 : i - 1]),
			.right_entry (entry_w[(i == DEPTH - 1) ? i : i + 1]),
			.entry       (entry_w[i]),
			.ge          (ge_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q  <= accept;
			done_q  <= busy_q;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			val_s1 <= value;
		end
		if (busy_q) begin
			popped_q    <= (ctl.op == OP_POP) ? entry_w[0] : '0;
			empty_err_q <= (req_s1 == REQ_POP) && is_empty;
			full_err_q  <= ((req_s1 == REQ_INSERT) || (req_s1 == REQ_PUSH)) && is_full;
			occ_q       <= count_ext[OCC_W-1:0];
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign popped_value = popped_q;
	assign empty_error  = empty_err_q;
	assign full_error   = full_err_q;
	assign occupancy    = occ_q;

endmodule

FILE: rtl/siq_checker.sv
// Port-level checker for the sorted insert queue, bound to the top level.
// Depends on siq_pkg and sorted_insert_queue_core_macros.svh.
`timescale 1ns / 1ps
`include "sorted_insert_queue_core_macros.svh"

module siq_checker #(
	parameter int DEPTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [siq_pkg::DATA_W-1:0] popped_value,
	input logic                          empty_error,
	input logic                          full_error,
	input logic [siq_pkg::OCC_W-1:0]     occupancy
);
	import siq_pkg::*;

	logic accept;
	logic empty_clean;
	logic full_occ;
	assign accept      = start && !busy;
	assign empty_clean = (occupancy == '0) && (popped_value == '0);
	assign full_occ    = (occupancy == OCC_W'(DEPTH));

	`SIQ_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy not raised after a transfer")
	`SIQ_ASSERT_SAME(a_done_two_later, accept, ##2 done, "no result two cycles after transfer")
	`SIQ_ASSERT_SAME(a_flags_exclusive, done, !(empty_error && full_error), "both error flags set")
	`SIQ_ASSERT_SAME(a_empty_result, done && empty_error, empty_clean, "empty pop reports data")
	`SIQ_ASSERT_SAME(a_full_result, done && full_error, full_occ, "full error with bad occupancy")

endmodule

bind sorted_insert_queue_core siq_checker #(.DEPTH(DEPTH)) u_siq_checker (.*);

FILE: tb/sv/tb_sorted_insert_queue_core.sv
// Self-checking testbench for sorted_insert_queue_core: directed and random requests,
// each result checked against a behavioral copy of the list kept in the bench.
// Depends on siq_pkg and the sorted_insert_queue_core RTL.
`timescale 1ns / 1ps

module tb_sorted_insert_queue_core;
	import siq_pkg::*;

	localparam int Q_DEPTH = 16;
	localparam int RAND_ITEMS = 1280;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam data_t VAL_MAX = 32'h7FFF_FFFF;
	localparam data_t VAL_MIN = 32'h8000_0000;
	localparam data_t VAL_NEG_ONE = 32'hFFFF_FFFF;

	// Stream modes for the random part.
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct {
		logic [REQ_W-1:0] req;
		data_t val;
	} queue_request_t;

	typedef struct {
		data_t popped;
		logic empty_err;
		logic full_err;
		logic [OCC_W-1:0] occ;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [REQ_W-1:0] req_type;
	data_t value;
	logic done;
	data_t popped_value;
	logic empty_error;
	logic full_error;
	logic [OCC_W-1:0] occupancy;

	queue_request_t pending_requests[$];
	queue_result_t expected_results[$];

	// Bench copy of the list contents, head at index 0.
	data_t list_entries[Q_DEPTH];
	int list_count = 0;

	int error_count = 0;
	int cycle_count = 0;
	bit xfer_seen = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	queue_result_t want;

	sorted_insert_queue_core #(
		.DEPTH(Q_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.popped_value(popped_value),
		.empty_error(empty_error),
		.full_error(full_error),
		.occupancy(occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the bench list and returns the result it should give.
	function automatic queue_result_t apply_request(logic [REQ_W-1:0] req, data_t val);
		queue_result_t res;
		int pos;
		int i;
		bit found;
		res.popped = '0;
		res.empty_err = 1'b0;
		res.full_err = 1'b0;
		case (req)
			REQ_INSERT, REQ_PUSH: begin
				if (list_count >= Q_DEPTH) begin
					res.full_err = 1'b1;
				end else begin
					pos = 0;
					if (req == REQ_INSERT) begin
						// A new value goes in front of the first entry that is not smaller.
						pos = list_count;
						found = 1'b0;
						for (i = 0; i < list_count && !found; i++) begin
							if (list_entries[i] >= val) begin
								pos = i;
								found = 1'b1;
							end
						end
					end
					for (i = list_count; i > pos; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[pos] = val;
					list_count++;
				end
			end
			REQ_POP: begin
				if (list_count == 0) begin
					res.empty_err = 1'b1;
				end else begin
					res.popped = list_entries[0];
					for (i = 1; i < list_count; i++)
						list_entries[i-1] = list_entries[i];
					list_count--;
				end
			end
			default: begin
			end
		endcase
		res.occ = list_count[OCC_W-1:0];
		return res;
	endfunction

	function automatic data_t pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		// Small values make equal entries and ties common.
		if (sel < 3)
			return int'($urandom_range(0, 8)) - 4;
		if (sel == 3) begin
			case ($urandom_range(0, 3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return '0;
				default: return VAL_NEG_ONE;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [REQ_W-1:0] pick_request(int mode);
		int roll;
		int ins_lim;
		int push_lim;
		int pop_lim;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				ins_lim = 55; push_lim = 80; pop_lim = 97;
			end
			MODE_DRAIN: begin
				ins_lim = 15; push_lim = 25; pop_lim = 97;
			end
			default: begin
				ins_lim = 35; push_lim = 55; pop_lim = 97;
			end
		endcase
		if (roll < ins_lim)
			return REQ_INSERT;
		if (roll < push_lim)
			return REQ_PUSH;
		if (roll < pop_lim)
			return REQ_POP;
		return REQ_UNUSED;
	endfunction

	task automatic add_request(logic [REQ_W-1:0] req, data_t val);
		queue_request_t item;
		item.req = req;
		item.val = val;
		pending_requests.push_back(item);
	endtask

	task automatic compare_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			error_count++;
		end
	endtask

	// Driver: inputs change on the falling edge; the front request is held until a
	// transfer is seen, then bursts and gaps decide when the next one is offered.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (xfer_seen) begin
				xfer_seen = 1'b0;
				void'(pending_requests.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (gap_left > 0 || pending_requests.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				start <= 1'b0;
				req_type <= REQ_W'($urandom);
				value <= $urandom;
			end else begin
				start <= 1'b1;
				req_type <= pending_requests[0].req;
				value <= pending_requests[0].val;
			end
		end
	end

	// Monitor: checks each result against the oldest expectation, then records the
	// expectation for a request taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, popped_value %0d occupancy %0d",
						$time, popped_value, occupancy);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("popped_value", want.popped, popped_value);
					compare_field("empty_error", want.empty_err, empty_error);
					compare_field("full_error", want.full_err, full_error);
					compare_field("occupancy", want.occ, occupancy);
				end
			end
			if (start && !busy) begin
				expected_results.push_back(apply_request(req_type, value));
				xfer_seen = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		int i;
		int mode;
		int seg_len;
		logic [REQ_W-1:0] req;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		value = '0;

		// Directed: empty-list cases, extremes, ties, then fill past full.
		add_request(REQ_POP, '0);
		add_request(REQ_UNUSED, 32'h1234_5678);
		add_request(REQ_INSERT, VAL_MAX);
		add_request(REQ_INSERT, VAL_MIN);
		add_request(REQ_INSERT, '0);
		add_request(REQ_INSERT, VAL_NEG_ONE);
		add_request(REQ_INSERT, '0);
		add_request(REQ_PUSH, VAL_MAX);
		add_request(REQ_INSERT, 32'hAAAA_AAAA);
		add_request(REQ_INSERT, 32'h5555_5555);
		for (i = 0; i < Q_DEPTH - 8; i++)
			add_request(REQ_INSERT, pick_value());
		add_request(REQ_INSERT, VAL_MIN);
		add_request(REQ_PUSH, VAL_MAX);
		add_request(REQ_UNUSED, '0);
		add_request(REQ_POP, '0);
		add_request(REQ_POP, '0);

		// Random: segments that lean toward filling, draining or neither, so the list
		// swings between empty and full many times.
		n = 0;
		while (n < RAND_ITEMS) begin
			mode = $urandom_range(MODE_FILL, MODE_MIXED);
			seg_len = $urandom_range(10, 60);
			for (i = 0; i < seg_len && n < RAND_ITEMS; i++) begin
				req = pick_request(mode);
				add_request(req, pick_value());
				n++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/siq_pkg.sv
rtl/siq_cell.sv
rtl/sorted_insert_queue_core.sv
rtl/siq_checker.sv
tb/sv/tb_sorted_insert_queue_core.sv
